>>> sv/esc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_TEMP_CAL  = 3'd0,
		REG_PRES_LOW  = 3'd1,
		REG_PRES_HIGH = 3'd2,
		REG_PRES_NINTH = 3'd3,
		REG_HUM_CAL   = 3'd4,
		REG_CELSIUS   = 3'd5
	} cfg_reg_t;

	localparam int FRONT_STAGES = 13;
	localparam int DIV_STAGES   = 32;
	localparam int BACK_STAGES  = 3;

	localparam logic signed [31:0] C_PRES_OFS  = 32'sd64000;
	localparam logic signed [31:0] C_RAW_FULL  = 32'sd1048576;
	localparam logic signed [31:0] C_PRES_MUL  = 32'sd3125;
	localparam logic signed [31:0] C_HUM_OFS   = 32'sd76800;
	localparam logic signed [31:0] C_HUM_RND   = 32'sd16384;
	localparam logic signed [31:0] C_HUM_BIAS  = 32'sd2097152;
	localparam logic signed [31:0] C_HUM_MAX   = 32'sd419430400;
	localparam logic signed [31:0] C_ONE_Q15   = 32'sd32768;
	localparam logic signed [31:0] C_HUM_RND2  = 32'sd8192;
	localparam logic signed [31:0] C_FAHR_OFS  = 32'sd3200;
	localparam logic signed [31:0] C_TEMP_RND  = 32'sd128;
	localparam logic signed [31:0] C_PRES_MAX  = 32'sd131071;
	localparam logic signed [31:0] C_TEMP_MIN  = -32'sd32768;
	localparam logic signed [31:0] C_TEMP_MAX  = 32'sd32767;
	// Reciprocal of five: floor(n / 5) == (n * C_RECIP5) >> 34 for any 32-bit n.
	localparam logic [63:0] C_RECIP5 = 64'h00000000CCCCCCCD;

	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
		logic [15:0] raw_humidity;
	} in_t;

	typedef struct packed {
		logic signed [15:0] temperature;
		logic [16:0]        pressure_pa;
		logic [16:0]        humidity_q10;
		logic               pressure_invalid;
	} out_t;

	typedef struct packed {
		logic [47:0] temp_cal;
		logic [63:0] pres_low;
		logic [63:0] pres_high;
		logic [15:0] pres_ninth;
		logic [63:0] hum_cal;
		logic        celsius;
	} cal_t;

	// Results that ride along with the division.
	typedef struct packed {
		logic               big;
		logic               inv;
		logic signed [15:0] temp;
		logic [16:0]        hum;
	} side_t;

	typedef struct packed {
		logic [31:0] num;
		logic [31:0] den;
		side_t       side;
	} div_in_t;

	typedef struct packed {
		logic [31:0] quo;
		side_t       side;
	} div_out_t;

	function automatic logic signed [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic signed [31:0] sx12(input logic [11:0] v);
		return {{20{v[11]}}, v};
	endfunction

	function automatic logic signed [31:0] sx8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

endpackage

`default_nettype wire

>>> sv/esc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module esc_front import esc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  in_t     sample,
	input  cal_t    cal,
	output logic    out_valid,
	output div_in_t out_word
);

	typedef struct packed {
		logic [31:0]        num;
		logic [31:0]        den;
		logic               big;
		logic               inv;
		logic signed [15:0] temp;
	} pcarry_t;

	logic [FRONT_STAGES-1:0] vld_s;

	logic signed [31:0] t1, t2, t3;
	logic signed [31:0] p1, p2, p3, p4, p5, p6;
	logic signed [31:0] h1, h2, h3, h4, h5, h6;
	logic signed [31:0] adc_t;

	logic signed [31:0] x1_s1, d_s1;
	logic signed [31:0] m1_s2, dd_s2;
	logic signed [31:0] a_s3, m2_s3;
	logic signed [31:0] fine_s4;
	logic signed [31:0] pa_s5, q_s5, hq_s5, tc_s5;
	logic signed [31:0] qq_s6, a5_s6, p2a_s6, h5q_s6, qh6_s6, qh3_s6, tn_s6, tc_s6;
	logic signed [31:0] b1_s7, c1_s7, a5_s7, p2a_s7, av_s7, x_s7, y_s7, tc_s7;
	logic [31:0]        mag_s7;
	logic               neg_s7;
	logic signed [31:0] pb_s8, aa_s8, xy_s8, av_s8, tc_s8;
	logic [31:0]        quo_s8;
	logic               neg_s8;
	logic signed [31:0] pden_s9, pnum_s9, hm_s9, av_s9;
	logic signed [15:0] temp_s9;
	logic signed [31:0] qh_s10, qh_s11, qh_s12;
	logic signed [31:0] rr_s11, t_s12;
	logic [16:0]        hum_s13;
	pcarry_t            pc_s10, pc_s11, pc_s12, pc_s13;
	logic [19:0]        adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7, adcp_s8;
	logic [15:0]        adch_s1, adch_s2, adch_s3, adch_s4, adch_s5, adch_s6;

	logic signed [31:0] x1_d, d_d, fine5, tn_d, pa_d;
	logic signed [31:0] av_d, bsum, pb_d, csum, aa_d, hv, tf, tsel, pnum_d, pden_sh;
	logic signed [31:0] hbb, r_d, hq2;
	logic [63:0]        prod5;
	logic [31:0]        pnum_u;

	assign t1 = signed'({16'd0, cal.temp_cal[15:0]});
	assign t2 = sx16(cal.temp_cal[31:16]);
	assign t3 = sx16(cal.temp_cal[47:32]);
	assign p1 = signed'({16'd0, cal.pres_low[15:0]});
	assign p2 = sx16(cal.pres_low[31:16]);
	assign p3 = sx16(cal.pres_low[47:32]);
	assign p4 = sx16(cal.pres_low[63:48]);
	assign p5 = sx16(cal.pres_high[15:0]);
	assign p6 = sx16(cal.pres_high[31:16]);
	assign h1 = signed'({24'd0, cal.hum_cal[7:0]});
	assign h2 = sx16(cal.hum_cal[23:8]);
	assign h3 = signed'({24'd0, cal.hum_cal[31:24]});
	assign h4 = sx12(cal.hum_cal[43:32]);
	assign h5 = sx12(cal.hum_cal[55:44]);
	assign h6 = sx8(cal.hum_cal[63:56]);
	assign adc_t = signed'({12'd0, sample.raw_temperature});

	always_comb begin
		x1_d   = (adc_t >>> 3) - (t1 <<< 1);
		d_d    = (adc_t >>> 4) - t1;
		pa_d   = (fine_s4 >>> 1) - C_PRES_OFS;
		fine5  = (fine_s4 <<< 2) + fine_s4;
		tn_d   = (tc_s5 <<< 3) + tc_s5 + ((tc_s5 < 0) ? -32'sd2 : 32'sd2);
		av_d   = ((signed'({16'd0, adch_s6}) <<< 14) - (h4 <<< 20) - h5q_s6 + C_HUM_RND) >>> 15;
		bsum   = b1_s7 + (a5_s7 <<< 1);
		pb_d   = (bsum >>> 2) + (p4 <<< 16);
		csum   = (c1_s7 >>> 3) + (p2a_s7 >>> 1);
		aa_d   = C_ONE_Q15 + (csum >>> 18);
		prod5  = {32'd0, mag_s7} * C_RECIP5;
		hv     = (xy_s8 >>> 10) + C_HUM_BIAS;
		tf     = (neg_s8 ? -signed'(quo_s8) : signed'(quo_s8)) + C_FAHR_OFS;
		tsel   = cal.celsius ? tc_s8 : tf;
		pnum_d = ((C_RAW_FULL - signed'({12'd0, adcp_s8})) - (pb_s8 >>> 12)) * C_PRES_MUL;
		pnum_u = unsigned'(pnum_s9);
		pden_sh = pden_s9 >>> 15;
		hbb    = (hm_s9 + C_HUM_RND2) >>> 14;
		r_d    = qh_s10 >>> 15;
		hq2    = qh_s12 - (t_s12 >>> 4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[FRONT_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Temperature and fine temperature.
			x1_s1   <= x1_d;
			d_s1    <= d_d;
			adcp_s1 <= sample.raw_pressure;
			adch_s1 <= sample.raw_humidity;

			m1_s2   <= x1_s1 * t2;
			dd_s2   <= d_s1 * d_s1;
			adcp_s2 <= adcp_s1;
			adch_s2 <= adch_s1;

			a_s3    <= m1_s2 >>> 11;
			m2_s3   <= (dd_s2 >>> 12) * t3;
			adcp_s3 <= adcp_s2;
			adch_s3 <= adch_s2;

			fine_s4 <= a_s3 + (m2_s3 >>> 14);
			adcp_s4 <= adcp_s3;
			adch_s4 <= adch_s3;

			pa_s5   <= pa_d;
			q_s5    <= pa_d >>> 2;
			hq_s5   <= fine_s4 - C_HUM_OFS;
			tc_s5   <= (fine5 + C_TEMP_RND) >>> 8;
			adcp_s5 <= adcp_s4;
			adch_s5 <= adch_s4;

			qq_s6   <= q_s5 * q_s5;
			a5_s6   <= pa_s5 * p5;
			p2a_s6  <= p2 * pa_s5;
			h5q_s6  <= h5 * hq_s5;
			qh6_s6  <= hq_s5 * h6;
			qh3_s6  <= hq_s5 * h3;
			tn_s6   <= tn_d;
			tc_s6   <= tc_s5;
			adcp_s6 <= adcp_s5;
			adch_s6 <= adch_s5;

			b1_s7   <= (qq_s6 >>> 11) * p6;
			c1_s7   <= p3 * (qq_s6 >>> 13);
			a5_s7   <= a5_s6;
			p2a_s7  <= p2a_s6;
			av_s7   <= av_d;
			x_s7    <= qh6_s6 >>> 10;
			y_s7    <= (qh3_s6 >>> 11) + C_ONE_Q15;
			neg_s7  <= tn_s6 < 0;
			mag_s7  <= unsigned'((tn_s6 < 0) ? -tn_s6 : tn_s6);
			tc_s7   <= tc_s6;
			adcp_s7 <= adcp_s6;

			pb_s8   <= pb_d;
			aa_s8   <= aa_d;
			xy_s8   <= x_s7 * y_s7;
			av_s8   <= av_s7;
			quo_s8  <= {4'd0, prod5[61:34]};
			neg_s8  <= neg_s7;
			tc_s8   <= tc_s7;
			adcp_s8 <= adcp_s7;

			pden_s9 <= aa_s8 * p1;
			pnum_s9 <= pnum_d;
			hm_s9   <= hv * h2;
			av_s9   <= av_s8;
			if (tsel < C_TEMP_MIN) begin
				temp_s9 <= C_TEMP_MIN[15:0];
			end else if (tsel > C_TEMP_MAX) begin
				temp_s9 <= C_TEMP_MAX[15:0];
			end else begin
				temp_s9 <= tsel[15:0];
			end

			// Numerators at or above 2^31 are divided first and doubled afterwards.
			pc_s10.den  <= unsigned'(pden_sh);
			pc_s10.inv  <= pden_sh == 32'sd0;
			pc_s10.big  <= pnum_u[31];
			pc_s10.num  <= pnum_u[31] ? pnum_u : {pnum_u[30:0], 1'b0};
			pc_s10.temp <= temp_s9;
			qh_s10      <= av_s9 * hbb;

			rr_s11 <= r_d * r_d;
			qh_s11 <= qh_s10;
			pc_s11 <= pc_s10;

			t_s12  <= (rr_s11 >>> 7) * h1;
			qh_s12 <= qh_s11;
			pc_s12 <= pc_s11;

			if (hq2 < 0) begin
				hum_s13 <= '0;
			end else if (hq2 > C_HUM_MAX) begin
				hum_s13 <= C_HUM_MAX[28:12];
			end else begin
				hum_s13 <= hq2[28:12];
			end
			pc_s13 <= pc_s12;
		end
	end

	assign out_valid          = vld_s[FRONT_STAGES-1];
	assign out_word.num       = pc_s13.num;
	assign out_word.den       = pc_s13.den;
	assign out_word.side.big  = pc_s13.big;
	assign out_word.side.inv  = pc_s13.inv;
	assign out_word.side.temp = pc_s13.temp;
	assign out_word.side.hum  = hum_s13;

endmodule

`default_nettype wire

>>> sv/esc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module esc_div import esc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  div_in_t  in_word,
	output logic     out_valid,
	output div_out_t out_word
);

	// Entry 0 is the input; entry i holds the word after i quotient bits.
	logic        vld_s  [0:DIV_STAGES];
	logic [31:0] rem_s  [0:DIV_STAGES];
	logic [31:0] num_s  [0:DIV_STAGES];
	logic [31:0] den_s  [0:DIV_STAGES];
	side_t       side_s [0:DIV_STAGES];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign num_s[0]  = in_word.num;
	assign den_s[0]  = in_word.den;
	assign side_s[0] = in_word.side;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
		logic [32:0] trial;
		logic [32:0] diff;
		logic        ge;

		always_comb begin
			trial = {rem_s[i], num_s[i][31]};
			diff  = trial - {1'b0, den_s[i]};
			ge    = trial >= {1'b0, den_s[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[31:0] : trial[31:0];
				num_s[i+1]  <= {num_s[i][30:0], ge};
				den_s[i+1]  <= den_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid     = vld_s[DIV_STAGES];
	assign out_word.quo  = num_s[DIV_STAGES];
	assign out_word.side = side_s[DIV_STAGES];

endmodule

`default_nettype wire

>>> sv/esc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module esc_back import esc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  div_out_t in_word,
	input  cal_t     cal,
	output logic     out_valid,
	output out_t     out_word
);

	logic [BACK_STAGES-1:0] vld_s;

	logic signed [31:0] p7, p8, p9;
	logic [31:0]        p_d;
	logic [31:0]        p_s1, p_s2;
	logic [31:0]        sq_s1;
	logic signed [31:0] pb_s1;
	logic signed [31:0] a_s2, b_s2;
	side_t              side_s1, side_s2;
	logic signed [31:0] pres;
	out_t               res_s3;

	assign p7 = sx16(cal.pres_high[47:32]);
	assign p8 = sx16(cal.pres_high[63:48]);
	assign p9 = sx16(cal.pres_ninth);

	always_comb begin
		p_d  = in_word.side.big ? {in_word.quo[30:0], 1'b0} : in_word.quo;
		pres = signed'(p_s2) + ((a_s2 + b_s2 + p7) >>> 4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[BACK_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= p_d;
			sq_s1   <= {3'd0, p_d[31:3]} * {3'd0, p_d[31:3]};
			pb_s1   <= signed'({2'd0, p_d[31:2]}) * p8;
			side_s1 <= in_word.side;

			p_s2    <= p_s1;
			a_s2    <= (p9 * signed'({13'd0, sq_s1[31:13]})) >>> 12;
			b_s2    <= pb_s1 >>> 13;
			side_s2 <= side_s1;

			res_s3.temperature      <= side_s2.temp;
			res_s3.humidity_q10     <= side_s2.hum;
			res_s3.pressure_invalid <= side_s2.inv;
			if (side_s2.inv || pres < 0) begin
				res_s3.pressure_pa <= '0;
			end else if (pres > C_PRES_MAX) begin
				res_s3.pressure_pa <= C_PRES_MAX[16:0];
			end else begin
				res_s3.pressure_pa <= pres[16:0];
			end
		end
	end

	assign out_valid = vld_s[BACK_STAGES-1];
	assign out_word  = res_s3;

endmodule

`default_nettype wire

>>> sv/environment_sensor_compensation.sv
// Environment sensor compensation, 32-bit integer scheme.
// The sample channel (sample_valid, sample_stall, sample) takes one raw
// pressure, temperature and humidity word; the result channel (result_valid,
// result_stall, result) returns temperature, pressure, humidity and the
// pressure-invalid flag for each word, in order.
// Calibration is written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write calibration only while no word
// is in flight.
// The datapath is a 48-stage pipeline: 13 stages of compensation arithmetic,
// a 32-stage unsigned divider that resolves one quotient bit per stage, and
// 3 stages of pressure correction ending in the output register.
// One word is taken every cycle while the result side is not stalled.
// When the receiver raises result_stall with a result waiting, the whole
// pipeline holds and sample_stall is raised in the same cycle.
// Reset clears all calibration registers to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module environment_sensor_compensation import esc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  in_t         sample,
	output logic        result_valid,
	input  logic        result_stall,
	output out_t        result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cal_t     cal_q;
	logic     adv;
	logic     front_valid;
	div_in_t  front_word;
	logic     div_valid;
	div_out_t div_word;

	assign adv          = !(result_valid && result_stall);
	assign sample_stall = !adv;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TEMP_CAL: begin
					cal_q.temp_cal <= cfg_data[47:0];
				end
				REG_PRES_LOW: begin
					cal_q.pres_low <= cfg_data;
				end
				REG_PRES_HIGH: begin
					cal_q.pres_high <= cfg_data;
				end
				REG_PRES_NINTH: begin
					cal_q.pres_ninth <= cfg_data[15:0];
				end
				REG_HUM_CAL: begin
					cal_q.hum_cal <= cfg_data;
				end
				REG_CELSIUS: begin
					cal_q.celsius <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	esc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sample_valid),
		.sample    (sample),
		.cal       (cal_q),
		.out_valid (front_valid),
		.out_word  (front_word)
	);

	esc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (front_valid),
		.in_word   (front_word),
		.out_valid (div_valid),
		.out_word  (div_word)
	);

	esc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (div_valid),
		.in_word   (div_word),
		.cal       (cal_q),
		.out_valid (result_valid),
		.out_word  (result)
	);

endmodule

`default_nettype wire

>>> tb/environment_sensor_compensation_tb.sv
`timescale 1ns / 1ps

module environment_sensor_compensation_tb;
	import esc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_stall;
	in_t         sample;
	logic        result_valid;
	logic        result_stall;
	out_t        result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	environment_sensor_compensation uut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam int LATENCY = 48;
	localparam int IDLE_LIMIT = 2000;

	// Local copy of the calibration.
	logic [47:0] cal_temp;
	logic [63:0] cal_plow, cal_phigh, cal_hum;
	logic [15:0] cal_p9;
	logic        cal_celsius;

	out_t expected_readings[$];
	int   mismatches;
	int   words_sent;
	int   words_checked;
	int   idle_cycles;
	int   stall_left;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic signed [31:0] sar(logic signed [31:0] a, int n);
		return a >>> n;
	endfunction

	function automatic out_t compensate(in_t s);
		logic signed [31:0] adc_p, adc_t, adc_h;
		logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [31:0] h1, h2, h3, h4, h5, h6;
		logic signed [31:0] a, b, d, q, fine, tc, pres;
		logic [31:0] p, dv;
		longint tout;
		out_t r;
		adc_p = {12'd0, s.raw_pressure};
		adc_t = {12'd0, s.raw_temperature};
		adc_h = {16'd0, s.raw_humidity};
		t1 = {16'd0, cal_temp[15:0]};
		t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
		t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
		p1 = {16'd0, cal_plow[15:0]};
		p2 = {{16{cal_plow[31]}}, cal_plow[31:16]};
		p3 = {{16{cal_plow[47]}}, cal_plow[47:32]};
		p4 = {{16{cal_plow[63]}}, cal_plow[63:48]};
		p5 = {{16{cal_phigh[15]}}, cal_phigh[15:0]};
		p6 = {{16{cal_phigh[31]}}, cal_phigh[31:16]};
		p7 = {{16{cal_phigh[47]}}, cal_phigh[47:32]};
		p8 = {{16{cal_phigh[63]}}, cal_phigh[63:48]};
		p9 = {{16{cal_p9[15]}}, cal_p9};
		h1 = {24'd0, cal_hum[7:0]};
		h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
		h3 = {24'd0, cal_hum[31:24]};
		h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
		h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
		h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};
		r = '0;

		a = sar((sar(adc_t, 3) - (t1 <<< 1)) * t2, 11);
		d = sar(adc_t, 4) - t1;
		b = sar(sar(d * d, 12) * t3, 14);
		fine = a + b;
		tc = sar(fine * 5 + 128, 8);

		a = sar(fine, 1) - 32'sd64000;
		q = sar(a, 2);
		b = sar(q * q, 11) * p6;
		b = b + ((a * p5) <<< 1);
		b = sar(b, 2) + (p4 <<< 16);
		a = sar(sar(p3 * sar(q * q, 13), 3) + sar(p2 * a, 1), 18);
		a = sar((32'sd32768 + a) * p1, 15);
		if (a == 0) begin
			r.pressure_invalid = 1'b1;
		end else begin
			dv = a;
			p = ((32'd1048576 - adc_p) - sar(b, 12)) * 32'd3125;
			if (p < 32'h80000000) p = (p << 1) / dv;
			else p = (p / dv) * 32'd2;
			a = sar(p9 * $signed(((p >> 3) * (p >> 3)) >> 13), 12);
			b = sar($signed(p >> 2) * p8, 13);
			pres = $signed(p) + sar(a + b + p7, 4);
			if (pres < 0) r.pressure_pa = '0;
			else if (pres > 131071) r.pressure_pa = 17'h1FFFF;
			else r.pressure_pa = pres[16:0];
		end

		q = fine - 32'sd76800;
		a = sar((adc_h <<< 14) - (h4 <<< 20) - h5 * q + 32'sd16384, 15);
		b = sar(sar(q * h6, 10) * (sar(q * h3, 11) + 32'sd32768), 10);
		b = sar((b + 32'sd2097152) * h2 + 32'sd8192, 14);
		q = a * b;
		q = q - sar(sar(sar(q, 15) * sar(q, 15), 7) * h1, 4);
		if (q < 0) q = 0;
		if (q > 32'sd419430400) q = 32'sd419430400;
		r.humidity_q10 = q[28:12];

		tout = tc;
		if (!cal_celsius) begin
			// Integer division truncates toward zero, as the rounding expects.
			if (tout >= 0) tout = (tout * 9 + 2) / 5 + 3200;
			else tout = (tout * 9 - 2) / 5 + 3200;
		end
		if (tout < -32768) tout = -32768;
		if (tout > 32767) tout = 32767;
		r.temperature = tout[15:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want,
			words_checked);
	endtask

	// Result checker; the receiver draws a stall length for every word it takes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_readings.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					out_t e;
					e = expected_readings.pop_front();
					if (result.temperature !== e.temperature)
						report_mismatch("temperature", result.temperature, e.temperature);
					if (result.pressure_pa !== e.pressure_pa)
						report_mismatch("pressure_pa", result.pressure_pa, e.pressure_pa);
					if (result.humidity_q10 !== e.humidity_q10)
						report_mismatch("humidity_q10", result.humidity_q10, e.humidity_q10);
					if (result.pressure_invalid !== e.pressure_invalid)
						report_mismatch("pressure_invalid", result.pressure_invalid,
							e.pressure_invalid);
				end
				words_checked++;
				stall_left = $urandom_range(0, 3);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			result_stall <= (stall_left != 0);
		end
	end

	// Watchdog on cycles where nothing moves.
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired");
			$display("status: fail");
			$finish;
		end
	end

	// Called at a rising edge; valid stays high after acceptance so that words
	// can follow back to back.
	task automatic send_word(in_t s);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		expected_readings.push_back(compensate(s));
		words_sent++;
	endtask

	task automatic drain;
		sample_valid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TEMP_CAL:   cal_temp = val[47:0];
			REG_PRES_LOW:   cal_plow = val;
			REG_PRES_HIGH:  cal_phigh = val;
			REG_PRES_NINTH: cal_p9 = val[15:0];
			REG_HUM_CAL:    cal_hum = val;
			REG_CELSIUS:    cal_celsius = val[0];
			default: ;
		endcase
	endtask

	function automatic in_t rand_word();
		in_t s;
		s.raw_pressure = 20'($urandom);
		s.raw_temperature = 20'($urandom);
		s.raw_humidity = 16'($urandom);
		return s;
	endfunction

	// Calibration typical of a real part, so results land in range.
	task automatic load_typical_cal(logic celsius);
		write_reg(REG_TEMP_CAL, {16'hFC18, 16'd26435, 16'd27504});
		write_reg(REG_PRES_LOW, {16'd2855, 16'hD0B8, 16'hD3A1, 16'd36477});
		write_reg(REG_PRES_HIGH, {16'hFFF9, 16'd15500, 16'hFFF9, 16'd140});
		write_reg(REG_PRES_NINTH, 64'd6000);
		write_reg(REG_HUM_CAL, {8'd30, 12'd50, 12'd312, 8'd0, 16'd362, 8'd75});
		write_reg(REG_CELSIUS, {63'd0, celsius});
	endtask

	task automatic test_reset_calibration;
		// All-zero calibration: divisor is zero, so pressure is flagged invalid.
		send_word('0);
		send_word('1);
		repeat (4) send_word(rand_word());
		drain();
	endtask

	task automatic test_directed_extremes;
		in_t s;
		load_typical_cal(1'b1);
		send_word('0);
		send_word('1);
		s = '0; s.raw_pressure = '1; send_word(s);
		s = '0; s.raw_temperature = '1; send_word(s);
		s = '0; s.raw_humidity = '1; send_word(s);
		send_word({20'd415148, 20'd519888, 16'd32000});
		drain();
		write_reg(REG_CELSIUS, 64'd0);
		send_word({20'd415148, 20'd519888, 16'd32000});
		send_word({20'd415148, 20'd100, 16'd32000});
		send_word('1);
		drain();
		// Extreme words: wrapping, saturation and a zero divisor.
		write_reg(REG_TEMP_CAL, 64'hFFFF_FFFF_FFFF);
		write_reg(REG_PRES_LOW, 64'h7FFF_7FFF_7FFF_FFFF);
		write_reg(REG_PRES_HIGH, 64'h8000_8000_8000_8000);
		write_reg(REG_PRES_NINTH, 64'h8000);
		write_reg(REG_HUM_CAL, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word('0);
		send_word('1);
		send_word({20'd415148, 20'd519888, 16'd32000});
		drain();
		write_reg(REG_PRES_LOW, 64'h0);
		send_word({20'd415148, 20'd519888, 16'd32000});
		drain();
	endtask

	task automatic test_random_typical(int n);
		in_t s;
		load_typical_cal(1'($urandom_range(0, 1)));
		repeat (n) begin
			s = rand_word();
			if ($urandom_range(0, 3) != 0) begin
				s.raw_temperature = 20'($urandom_range(400000, 650000));
				s.raw_pressure = 20'($urandom_range(250000, 600000));
			end
			send_word(s);
		end
		drain();
	endtask

	task automatic test_random_calibration(int n);
		repeat (n) begin
			write_reg(REG_TEMP_CAL, {$urandom, $urandom});
			write_reg(REG_PRES_LOW, {$urandom, $urandom});
			write_reg(REG_PRES_HIGH, {$urandom, $urandom});
			write_reg(REG_PRES_NINTH, {$urandom, $urandom});
			write_reg(REG_HUM_CAL, {$urandom, $urandom});
			write_reg(REG_CELSIUS, {$urandom, $urandom});
			repeat (25) send_word(rand_word());
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cal_temp = '0; cal_plow = '0; cal_phigh = '0;
		cal_p9 = '0; cal_hum = '0; cal_celsius = 1'b0;
		mismatches = 0; words_sent = 0; words_checked = 0; idle_cycles = 0;
		stall_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_calibration();
		test_directed_extremes();
		test_random_typical(500);
		test_random_typical(500);
		test_random_calibration(34);
		$display("covered %0d words, %0d results checked, %0d mismatches", words_sent,
			words_checked, mismatches);
		$display("directed extremes, typical and random calibration, both units");
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> environment_sensor_compensation.f
sv/esc_pkg.sv
sv/esc_front.sv
sv/esc_div.sv
sv/esc_back.sv
sv/environment_sensor_compensation.sv
tb/environment_sensor_compensation_tb.sv
